// ----- design/eamf_pkg.sv -----
`timescale 1ns / 1ps

package eamf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 16;
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 12;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    // floor(v / 3) as (v * 2731) >> 13, exact for every v below 2**SUM_W
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;

    typedef enum logic {
        KIND_PIX = 1'b0,
        KIND_DRN = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        t_kind              kind;
        logic [COL_W-1:0]   col;
        logic [PIX_W-1:0]   pix;
        logic               emit_main;
        logic               main_full;
        logic               emit_edge;
        logic               edge_two;
        logic               top_ok;
        logic [1:0]         span;
        logic               two_rows;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   cnt;
        logic               row_end;
        logic               frame_end;
    } t_res;

    function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] v);
        logic [2*SUM_W-1:0] p;
        p = (2*SUM_W)'(v) * (2*SUM_W)'(DIV3_MUL);
        return SUM_W'(p >> DIV3_SHIFT);
    endfunction

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
        logic [WIDTH_W-1:0] w;
        w = raw;
        if (raw == '0) begin
            w = WIDTH_W'(1);
        end else if (raw > WIDTH_W'(MAX_WIDTH)) begin
            w = WIDTH_W'(MAX_WIDTH);
        end
        return w;
    endfunction

endpackage

// ----- design/eamf_ram.sv -----
`timescale 1ns / 1ps

module eamf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- design/eamf_fifo.sv -----
`timescale 1ns / 1ps

module eamf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  eamf_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output eamf_pkg::t_cmd o_data
);

    localparam int PTR_W = $clog2(eamf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(eamf_pkg::QUEUE_DEPTH + 1);

    eamf_pkg::t_cmd   r_mem [eamf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(eamf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/eamf_front.sv -----
`timescale 1ns / 1ps

module eamf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [eamf_pkg::PIX_W-1:0]          i_pix,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eamf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [eamf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_q_full,
    output logic                                o_push,
    output eamf_pkg::t_cmd                      o_cmd
);

    logic [eamf_pkg::WIDTH_W-1:0]  r_width,  n_width;
    logic [eamf_pkg::HEIGHT_W-1:0] r_height, n_height;
    logic [eamf_pkg::COL_W-1:0]    r_col,    n_col;
    logic [eamf_pkg::HEIGHT_W-1:0] r_row,    n_row;
    logic [eamf_pkg::COL_W-1:0]    r_dcol,   n_dcol;
    logic                          r_done,   n_done;
    logic                          accept;
    logic                          col_last;
    logic                          dcol_last;
    logic                          row_last;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_col     = r_col;
        n_row     = r_row;
        n_dcol    = r_dcol;
        n_done    = r_done;
        o_push    = 1'b0;
        o_cmd     = '0;
        accept    = i_valid && !i_q_full;
        col_last  = (eamf_pkg::WIDTH_W'(r_col) == r_width - eamf_pkg::WIDTH_W'(1));
        dcol_last = (eamf_pkg::WIDTH_W'(r_dcol) == r_width - eamf_pkg::WIDTH_W'(1));
        row_last  = (r_row == r_height - eamf_pkg::HEIGHT_W'(1));

        if (accept) begin
            if (i_op == eamf_pkg::KIND_PIX && !r_done) begin
                o_push          = 1'b1;
                o_cmd.kind      = eamf_pkg::KIND_PIX;
                o_cmd.col       = r_col;
                o_cmd.pix       = i_pix;
                o_cmd.emit_main = (r_row != '0) && (r_col != '0);
                o_cmd.main_full = (r_col > eamf_pkg::COL_W'(1));
                o_cmd.emit_edge = (r_row != '0) && col_last;
                o_cmd.edge_two  = (r_width != eamf_pkg::WIDTH_W'(1));
                o_cmd.top_ok    = (r_row > eamf_pkg::HEIGHT_W'(1));
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_done = 1'b1;
                        n_dcol = '0;
                    end else begin
                        n_row = r_row + eamf_pkg::HEIGHT_W'(1);
                    end
                end else begin
                    n_col = r_col + eamf_pkg::COL_W'(1);
                end
            end else if (i_op == eamf_pkg::KIND_DRN && r_done) begin
                o_push         = 1'b1;
                o_cmd.kind     = eamf_pkg::KIND_DRN;
                o_cmd.col      = (r_dcol == '0) ? '0 : r_dcol - eamf_pkg::COL_W'(1);
                o_cmd.span     = 2'(r_dcol != '0) + 2'(!dcol_last);
                o_cmd.two_rows = (r_height != eamf_pkg::HEIGHT_W'(1));
                o_cmd.last     = dcol_last;
                if (dcol_last) begin
                    n_col  = '0;
                    n_row  = '0;
                    n_dcol = '0;
                    n_done = 1'b0;
                end else begin
                    n_dcol = r_dcol + eamf_pkg::COL_W'(1);
                end
            end
        end

        if (i_cfg_valid) begin
            if (i_cfg_index == eamf_pkg::REG_WIDTH) begin
                n_width = eamf_pkg::eff_width(i_cfg_data[eamf_pkg::WIDTH_W-1:0]);
                n_col   = '0;
                n_row   = '0;
                n_dcol  = '0;
                n_done  = 1'b0;
            end else if (i_cfg_index == eamf_pkg::REG_HEIGHT) begin
                n_height = (i_cfg_data[eamf_pkg::HEIGHT_W-1:0] == '0) ?
                           eamf_pkg::HEIGHT_W'(1) : i_cfg_data[eamf_pkg::HEIGHT_W-1:0];
                n_col    = '0;
                n_row    = '0;
                n_dcol   = '0;
                n_done   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= eamf_pkg::eff_width(eamf_pkg::WIDTH_W'(eamf_pkg::WIDTH_RESET));
            r_height <= eamf_pkg::HEIGHT_W'(eamf_pkg::HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
            r_dcol   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_dcol   <= n_dcol;
            r_done   <= n_done;
        end
    end

endmodule

// ----- design/eamf_back.sv -----
`timescale 1ns / 1ps

module eamf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic           i_q_valid,
    input  eamf_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_res_valid,
    output eamf_pkg::t_res o_res
);

    localparam int PIX_W = eamf_pkg::PIX_W;
    localparam int SUM_W = eamf_pkg::SUM_W;
    localparam int CNT_W = eamf_pkg::CNT_W;
    localparam int COL_W = eamf_pkg::COL_W;

    logic [1:0]         r_sub;
    eamf_pkg::t_cmd     r_s2;
    logic               r_s2_v;
    logic               r_s2_first;
    logic               r_s2_last;
    logic [COL_W-1:0]   r_s2_addr;
    logic               r_main_p;
    logic               r_edge_p;
    logic               r_byp_hit;
    logic [PIX_W-1:0]   r_byp_old;
    logic [PIX_W-1:0]   r_byp_new;
    logic [PIX_W-1:0]   r_win [3][3];
    logic [SUM_W-1:0]   r_acc;

    logic               head_last;
    logic [COL_W-1:0]   issue_addr;
    logic               issue;
    logic               pend2;
    logic               s2_fin;
    logic               finish;
    logic               ram_we;
    logic [PIX_W-1:0]   old_rd;
    logic [PIX_W-1:0]   new_rd;
    logic [PIX_W-1:0]   old_d;
    logic [PIX_W-1:0]   new_d;
    logic [PIX_W-1:0]   nw [3][3];
    logic [SUM_W-1:0]   cs [3];
    logic [SUM_W-1:0]   drn_col;
    logic [SUM_W-1:0]   drn_sum;
    logic [CNT_W-1:0]   rows;
    logic [CNT_W-1:0]   main_cols;
    logic [CNT_W-1:0]   edge_cols;
    logic [CNT_W-1:0]   drn_cols;
    logic [CNT_W-1:0]   drn_rows;
    eamf_pkg::t_res     main_res;
    eamf_pkg::t_res     edge_res;
    eamf_pkg::t_res     drn_res;
    logic               has_emit;

    eamf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (eamf_pkg::MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (new_d),
        .i_re    (issue),
        .i_raddr (issue_addr),
        .o_rdata (old_rd)
    );

    eamf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (eamf_pkg::MAX_WIDTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (r_s2.pix),
        .i_re    (issue),
        .i_raddr (issue_addr),
        .o_rdata (new_rd)
    );

    always_comb begin
        head_last  = (i_q_cmd.kind == eamf_pkg::KIND_PIX) || (r_sub == i_q_cmd.span);
        issue_addr = i_q_cmd.col + COL_W'(r_sub);
        pend2      = (r_s2.kind == eamf_pkg::KIND_PIX) && r_main_p && r_edge_p;
        s2_fin     = !r_s2_v || !pend2;
        issue      = i_go && s2_fin && i_q_valid;
        o_q_pop    = issue && head_last;
        finish     = i_go && r_s2_v && s2_fin;
        ram_we     = finish && (r_s2.kind == eamf_pkg::KIND_PIX);
        old_d      = r_byp_hit ? r_byp_old : old_rd;
        new_d      = r_byp_hit ? r_byp_new : new_rd;

        for (int rr = 0; rr < 3; rr++) begin
            nw[rr][0] = r_win[rr][1];
            nw[rr][1] = r_win[rr][2];
        end
        nw[0][2] = old_d;
        nw[1][2] = new_d;
        nw[2][2] = r_s2.pix;

        for (int cc = 0; cc < 3; cc++) begin
            cs[cc] = (r_s2.top_ok ? SUM_W'(nw[0][cc]) : '0) + SUM_W'(nw[1][cc])
                   + SUM_W'(nw[2][cc]);
        end

        rows      = r_s2.top_ok    ? CNT_W'(3) : CNT_W'(2);
        main_cols = r_s2.main_full ? CNT_W'(3) : CNT_W'(2);
        edge_cols = r_s2.edge_two  ? CNT_W'(2) : CNT_W'(1);

        main_res.sum       = cs[2] + cs[1] + (r_s2.main_full ? cs[0] : '0);
        main_res.cnt       = rows * main_cols;
        main_res.row_end   = 1'b0;
        main_res.frame_end = 1'b0;

        edge_res.sum       = cs[2] + (r_s2.edge_two ? cs[1] : '0);
        edge_res.cnt       = rows * edge_cols;
        edge_res.row_end   = 1'b1;
        edge_res.frame_end = 1'b0;

        drn_col  = SUM_W'(new_d) + (r_s2.two_rows ? SUM_W'(old_d) : '0);
        drn_sum  = (r_s2_first ? '0 : r_acc) + drn_col;
        drn_cols = CNT_W'(r_s2.span) + CNT_W'(1);
        drn_rows = r_s2.two_rows ? CNT_W'(2) : CNT_W'(1);

        drn_res.sum       = drn_sum;
        drn_res.cnt       = drn_cols * drn_rows;
        drn_res.row_end   = r_s2.last;
        drn_res.frame_end = r_s2.last;

        if (r_s2.kind == eamf_pkg::KIND_PIX) begin
            has_emit = r_main_p || r_edge_p;
            o_res    = r_main_p ? main_res : edge_res;
        end else begin
            has_emit = r_s2_last;
            o_res    = drn_res;
        end
        o_res_valid = r_s2_v && has_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub     <= '0;
            r_s2_v    <= 1'b0;
            r_main_p  <= 1'b0;
            r_edge_p  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else if (i_go) begin
            if (!s2_fin) begin
                // first of two results leaves, the row end one stays
                r_main_p <= 1'b0;
            end else begin
                r_s2_v    <= i_q_valid;
                r_main_p  <= (i_q_cmd.kind == eamf_pkg::KIND_PIX) && i_q_cmd.emit_main;
                r_edge_p  <= (i_q_cmd.kind == eamf_pkg::KIND_PIX) && i_q_cmd.emit_edge;
                r_byp_hit <= i_q_valid && ram_we && (r_s2_addr == issue_addr);
                if (i_q_valid) begin
                    r_sub <= head_last ? 2'd0 : r_sub + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2       <= i_q_cmd;
            r_s2_addr  <= issue_addr;
            r_s2_first <= (r_sub == 2'd0);
            r_s2_last  <= head_last;
            r_byp_old  <= new_d;
            r_byp_new  <= r_s2.pix;
        end
        if (ram_we) begin
            r_win <= nw;
        end
        if (finish && r_s2.kind == eamf_pkg::KIND_DRN) begin
            r_acc <= drn_sum;
        end
    end

endmodule

// ----- design/eamf_mean.sv -----
`timescale 1ns / 1ps

module eamf_mean (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic                       i_valid,
    input  eamf_pkg::t_res             i_res,
    output logic                       o_valid,
    output logic [eamf_pkg::PIX_W-1:0] o_smoothed,
    output logic                       o_row_end,
    output logic                       o_frame_end
);

    localparam int SUM_W = eamf_pkg::SUM_W;
    localparam int CNT_W = eamf_pkg::CNT_W;

    logic             r_a_v;
    eamf_pkg::t_res   r_a;
    logic             r_b_v;
    eamf_pkg::t_res   r_b;
    logic [SUM_W-1:0] r_b_q3;
    logic [SUM_W-1:0] quot;

    always_comb begin
        unique case (r_b.cnt)
            CNT_W'(1): quot = r_b.sum;
            CNT_W'(2): quot = r_b.sum >> 1;
            CNT_W'(3): quot = r_b_q3;
            CNT_W'(4): quot = r_b.sum >> 2;
            CNT_W'(6): quot = r_b_q3 >> 1;
            CNT_W'(9): quot = eamf_pkg::div3(r_b_q3);
            default:   quot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_go) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            o_valid <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a         <= i_res;
            r_b         <= r_a;
            r_b_q3      <= eamf_pkg::div3(r_a.sum);
            o_smoothed  <= quot[eamf_pkg::PIX_W-1:0];
            o_row_end   <= r_b.row_end;
            o_frame_end <= r_b.frame_end;
        end
    end

endmodule

// ----- design/edge_aware_3x3_mean_filter.sv -----
`timescale 1ns / 1ps

// 3x3 box mean over a raster pixel stream; neighbors outside the image are left out of
// both sum and divisor. Pixels (tuser 0) enter one per clock while the command queue has
// room; a pixel in row r, column c gives output (r-1, c-1), and the last pixel of a row
// also gives (r-1, width-1), so that pixel stays in the execute stage until both have left.
// The last row is read out by drain beats (tuser 1), one output each, with one read of the
// two line buffers per needed column. A result passes the execute register, then the mean
// unit's r_a, r_b and output registers; the divider is a reciprocal multiply split over
// two registered stages. Writing either register restarts the frame.
module edge_aware_3x3_mean_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]                          s_axis_tuser,   // [0] op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] smoothed
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser,   // [0] frame_end
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eamf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [eamf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic           go;
    logic           q_full;
    logic           q_push;
    eamf_pkg::t_cmd q_in;
    logic           q_valid;
    logic           q_pop;
    eamf_pkg::t_cmd q_out;
    logic           res_valid;
    eamf_pkg::t_res res;

    assign go = !m_axis_tvalid || m_axis_tready;

    eamf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser[0]),
        .i_pix       (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    eamf_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    eamf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    eamf_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_valid     (res_valid),
        .i_res       (res),
        .o_valid     (m_axis_tvalid),
        .o_smoothed  (m_axis_tdata),
        .o_row_end   (m_axis_tlast),
        .o_frame_end (m_axis_tuser[0])
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import eamf_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_CYC   = 24;
    localparam int HOLD_CYC     = 250;
    localparam int HOLD_AT      = 300;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PRINT_MAX    = 50;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] pix;
    } beat_t;

    typedef struct packed {
        logic [7:0] smoothed;
        logic       row_end;
        logic       frame_end;
    } smooth_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    edge_aware_3x3_mean_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // filter model state
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [7:0]          older_line [MAX_WIDTH];
    logic [7:0]          newer_line [MAX_WIDTH];
    logic [7:0]          win [3][3];
    int                  col_pos;
    int                  row_pos;
    int                  drain_pos;
    logic                frame_done;

    beat_t   beat_q [$];
    smooth_t smooth_exp_q [$];
    beat_t   nxt_beat;
    smooth_t got_res;
    smooth_t want_res;

    int gap_pct = 16;
    int stall_pct = 16;
    int mismatches = 0;
    int pixel_beats = 0;
    int drain_beats = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int random_items = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        drain_pos = 0;
        frame_done = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
    endfunction

    function automatic logic [7:0] window_mean(input int lo, input logic top_ok);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        for (int rr = 0; rr < 3; rr++) begin
            if (rr > 0 || top_ok) begin
                for (int cc = lo; cc < 3; cc++) begin
                    sum += win[rr][cc];
                    cnt++;
                end
            end
        end
        return 8'(sum / cnt);
    endfunction

    task automatic predict_smoothed(input logic kind, input logic [7:0] pix);
        int   w;
        int   h;
        int   c;
        int   r;
        int   d;
        int   lo;
        int   hi;
        int   sum;
        int   cnt;
        logic last;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (kind == KIND_PIX) begin
            if (!frame_done) begin
                c = (col_pos >= w) ? w - 1 : col_pos;
                r = row_pos;
                for (int rr = 0; rr < 3; rr++) begin
                    win[rr][0] = win[rr][1];
                    win[rr][1] = win[rr][2];
                end
                win[0][2] = older_line[c];
                win[1][2] = newer_line[c];
                win[2][2] = pix;
                older_line[c] = newer_line[c];
                newer_line[c] = pix;
                if (r >= 1 && c >= 1)
                    smooth_exp_q.push_back('{window_mean((c >= 2) ? 0 : 1, r >= 2), 1'b0, 1'b0});
                if (r >= 1 && c == w - 1)
                    smooth_exp_q.push_back('{window_mean((w >= 2) ? 1 : 2, r >= 2), 1'b1, 1'b0});
                if (c == w - 1) begin
                    col_pos = 0;
                    if (r + 1 >= h) begin
                        frame_done = 1'b1;
                        drain_pos = 0;
                    end else begin
                        row_pos = r + 1;
                    end
                end else begin
                    col_pos = c + 1;
                end
            end
        end else if (frame_done) begin
            d = (drain_pos >= w) ? w - 1 : drain_pos;
            lo = (d >= 1) ? d - 1 : 0;
            hi = (d + 1 < w) ? d + 1 : d;
            sum = 0;
            cnt = 0;
            for (int cc = lo; cc <= hi; cc++) begin
                sum += newer_line[cc];
                cnt++;
                if (h >= 2) begin
                    sum += older_line[cc];
                    cnt++;
                end
            end
            last = (d == w - 1);
            smooth_exp_q.push_back('{8'(sum / cnt), last, last});
            if (last)
                restart_frame();
            else
                drain_pos = d + 1;
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_MAX)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_smoothed(s_axis_tuser[0], s_axis_tdata);
                if (s_axis_tuser[0] == KIND_PIX)
                    pixel_beats++;
                else
                    drain_beats++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    nxt_beat = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt_beat.pix;
                    s_axis_tuser  <= nxt_beat.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0]};
                results_seen++;
                if (smooth_exp_q.size() == 0) begin
                    flag_mismatch("unexpected beat, smoothed", got_res.smoothed, -1);
                end else begin
                    want_res = smooth_exp_q.pop_front();
                    if (got_res.smoothed !== want_res.smoothed)
                        flag_mismatch("smoothed", got_res.smoothed, want_res.smoothed);
                    if (got_res.row_end !== want_res.row_end)
                        flag_mismatch("row_end", got_res.row_end, want_res.row_end);
                    if (got_res.frame_end !== want_res.frame_end)
                        flag_mismatch("frame_end", got_res.frame_end, want_res.frame_end);
                end
            end
            // one long back-pressure window so the input side has to stall
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, smooth_exp_q.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic void push_beat(input t_kind k, input logic [7:0] p);
        beat_q.push_back('{k, p});
    endfunction

    function automatic logic [7:0] pick_pixel();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'd0;
        else if (roll < 20)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic settle();
        while (beat_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (smooth_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WIDTH)
            width_reg = val[WIDTH_W-1:0];
        else
            height_reg = val;
        restart_frame();
        cfg_writes++;
    endtask

    task automatic reconfigure(input logic [15:0] w, input logic [15:0] h);
        settle();
        if ($urandom_range(1)) begin
            write_reg(REG_HEIGHT, h);
            write_reg(REG_WIDTH, w);
        end else begin
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
        end
    endtask

    // well-formed frame with random content, optionally cut short or padded with noise
    task automatic queue_frame(input int w, input int h, input logic broken);
        int total;
        int cut;
        total = w * h;
        cut = broken ? $urandom_range(total - 1) : total;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(99) < 4)
                push_beat(KIND_DRN, 8'($urandom_range(255)));
            push_beat(KIND_PIX, pick_pixel());
            random_items++;
        end
        if (!broken) begin
            if ($urandom_range(99) < 25)
                repeat ($urandom_range(1, 2)) push_beat(KIND_PIX, 8'($urandom_range(255)));
            for (int d = 0; d < w; d++) begin
                push_beat(KIND_DRN, 8'($urandom_range(255)));
                random_items++;
            end
        end
    endtask

    initial begin
        int   round;
        int   wv;
        int   hv;
        logic broken;
        width_reg = WIDTH_W'(WIDTH_RESET);
        height_reg = HEIGHT_W'(HEIGHT_RESET);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        restart_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1 through zero width and height: early drain, pixel, ignored pixel, drain
        reconfigure(16'd0, 16'd0);
        push_beat(KIND_DRN, 8'hFF);
        push_beat(KIND_PIX, 8'd255);
        push_beat(KIND_PIX, 8'd17);
        push_beat(KIND_DRN, 8'h00);

        // single column
        reconfigure(16'd1, 16'd3);
        push_beat(KIND_PIX, 8'd255);
        push_beat(KIND_PIX, 8'd0);
        push_beat(KIND_PIX, 8'd255);
        push_beat(KIND_DRN, 8'h00);

        // single row
        reconfigure(16'd3, 16'd1);
        push_beat(KIND_PIX, 8'd0);
        push_beat(KIND_PIX, 8'd255);
        push_beat(KIND_PIX, 8'd128);
        repeat (3) push_beat(KIND_DRN, 8'h5A);

        // full window at maximum grey
        reconfigure(16'd3, 16'd3);
        repeat (9) push_beat(KIND_PIX, 8'd255);
        repeat (3) push_beat(KIND_DRN, 8'hA5);

        // widest row (all width bits set, clamps to max) and tallest frame, cut short
        reconfigure(16'hFFFF, 16'hFFFF);
        repeat (2 * MAX_WIDTH + 5) push_beat(KIND_PIX, pick_pixel());

        round = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (round == 6) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if (round == 12) begin
                gap_pct = 16;
                stall_pct = 16;
            end
            wv = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            hv = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
            if ($urandom_range(15) == 0) wv = 0;
            if ($urandom_range(15) == 0) hv = 0;
            reconfigure(16'(wv), 16'(hv));
            if (wv == 0) wv = 1;
            if (hv == 0) hv = 1;
            repeat ($urandom_range(1, 3)) begin
                broken = ($urandom_range(99) < 12);
                queue_frame(wv, hv, broken);
                if (broken) break;
            end
            round++;
        end

        settle();
        $display("run covered %0d pixel beats, %0d drain beats, %0d register writes",
                 pixel_beats, drain_beats, cfg_writes);
        $display("%0d smoothed results checked over %0d random configurations, %0d mismatches",
                 results_seen, round, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
design/eamf_pkg.sv
design/eamf_ram.sv
design/eamf_fifo.sv
design/eamf_front.sv
design/eamf_back.sv
design/eamf_mean.sv
design/edge_aware_3x3_mean_filter.sv
tb/tb_top.sv
